>>> rtl/core/correlating_branch_predictor_core_defines.svh
// Assertion macros for the correlating branch predictor core.
// Used by rtl/core/correlating_branch_predictor_core.sv; no other dependency.
// The macros sample on clk and are disabled while rst_n is low.
`ifndef CORRELATING_BRANCH_PREDICTOR_CORE_DEFINES_SVH
`define CORRELATING_BRANCH_PREDICTOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define CBP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

`define CBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define CBP_ASSERT_IMPLY(lbl, ante, cons)
`define CBP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/cbp_pkg.sv
// Shared types, constants and the counter update function for the predictor.
// No dependencies.
package cbp_pkg;

    typedef logic [1:0] counter_t;

    typedef struct packed {
        logic        predicted_taken;
        logic        mispredicted;
        logic [31:0] miss_total;
    } result_t;

    localparam counter_t    CTR_RESET = 2'd3;
    localparam logic [31:0] MISS_MAX  = 32'hFFFF_FFFF;
    localparam int          OQ_DEPTH  = 3;

    function automatic counter_t ctr_update(input counter_t cur, input logic taken);
        counter_t res;
        if (cur[1] == taken)
        begin
            res = {2{cur[1]}};
        end
        else
        begin
            case (cur)
                2'd0:    res = 2'd1;
                2'd1:    res = 2'd3;
                2'd2:    res = 2'd0;
                2'd3:    res = 2'd2;
                default: res = 2'd0;
            endcase
        end
        return res;
    endfunction

endpackage

>>> rtl/core/correlating_branch_predictor_core.sv
// Correlating branch predictor core: one resolved branch per cycle while branch_ready is high, one result word each.
// Depends on cbp_pkg and correlating_branch_predictor_core_defines.svh.
//
// A resolved branch word can be taken every cycle while branch_ready is high. The counter
// is read at the accepting edge, then updated and written back in the next cycle. The
// result word is written into the output queue by the update stage and offered on the
// outputs from there. The counter table does at most one read and one write per cycle.
// A write-to-read forwarding register covers back-to-back branches that hit the same
// counter. After reset the table is swept to the strongly-taken value, one entry per
// cycle, through all 2^(INDEX_BITS+HISTORY_BITS) entries (4096 with the default
// parameters); branch_ready stays low until it is done. A three-word output queue
// absorbs result_ready stalls. branch_ready drops once the queue and the update stage
// together hold three words.
`include "correlating_branch_predictor_core_defines.svh"

module correlating_branch_predictor_core #(
    parameter int INDEX_BITS   = 10,
    parameter int HISTORY_BITS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        branch_valid,
    output logic        branch_ready,
    input  logic [31:0] branch_address,
    input  logic        actual_taken,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        predicted_taken,
    output logic        mispredicted,
    output logic [31:0] miss_total
);

    localparam int       SLOT_BITS = INDEX_BITS + HISTORY_BITS;
    localparam int       ENTRIES   = 1 << SLOT_BITS;
    localparam logic [1:0] OQ_LAST = 2'(cbp_pkg::OQ_DEPTH - 1);
    localparam logic [2:0] OQ_FULL = 3'(cbp_pkg::OQ_DEPTH);

    cbp_pkg::counter_t ctr_mem [0:ENTRIES-1];

    logic                    clr_active_reg, clr_active_next;
    logic [SLOT_BITS-1:0]    clr_addr_reg, clr_addr_next;
    logic [HISTORY_BITS-1:0] hist_reg, hist_next;
    logic [HISTORY_BITS:0]   hist_ext;

    logic                    s1_valid_reg;
    logic [SLOT_BITS-1:0]    s1_slot_reg;
    logic                    s1_taken_reg;
    cbp_pkg::counter_t       rdata_reg;

    logic                    fwd_valid_reg;
    logic [SLOT_BITS-1:0]    fwd_slot_reg;
    cbp_pkg::counter_t       fwd_data_reg;

    logic [31:0]             tally_reg, tally_next;

    cbp_pkg::result_t        oq_mem_reg [0:cbp_pkg::OQ_DEPTH-1];
    logic [1:0]              oq_wptr_reg, oq_wptr_next;
    logic [1:0]              oq_rptr_reg, oq_rptr_next;
    logic [1:0]              oq_cnt_reg, oq_cnt_next;

    logic                    accept;
    logic                    pop;
    logic [SLOT_BITS-1:0]    slot_in;
    cbp_pkg::counter_t       cur;
    cbp_pkg::counter_t       ctr_new;
    logic                    s1_pred;
    logic                    s1_miss;
    logic                    mem_we;
    logic [SLOT_BITS-1:0]    mem_waddr;
    cbp_pkg::counter_t       mem_wdata;
    cbp_pkg::result_t        s1_result;
    cbp_pkg::result_t        head;

    // input side
    assign branch_ready = !clr_active_reg
                       && (({1'b0, oq_cnt_reg} + {2'b00, s1_valid_reg}) < OQ_FULL);
    assign accept   = branch_valid && branch_ready;
    assign slot_in  = {branch_address[INDEX_BITS-1:0], hist_reg};
    assign hist_ext = {actual_taken, hist_reg};

    // update stage
    always_comb
    begin
        if (fwd_valid_reg && (fwd_slot_reg == s1_slot_reg))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = rdata_reg;
        end
        s1_pred = cur[1];
        s1_miss = s1_pred ^ s1_taken_reg;
        ctr_new = cbp_pkg::ctr_update(cur, s1_taken_reg);
        tally_next = tally_reg;
        if (s1_valid_reg && s1_miss && (tally_reg != cbp_pkg::MISS_MAX))
        begin
            tally_next = tally_reg + 32'd1;
        end
        s1_result.predicted_taken = s1_pred;
        s1_result.mispredicted    = s1_miss;
        s1_result.miss_total      = tally_next;
    end

    always_comb
    begin
        mem_we = clr_active_reg || s1_valid_reg;
        if (clr_active_reg)
        begin
            mem_waddr = clr_addr_reg;
            mem_wdata = cbp_pkg::CTR_RESET;
        end
        else
        begin
            mem_waddr = s1_slot_reg;
            mem_wdata = ctr_new;
        end
    end

    // control next state
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + SLOT_BITS'(1);
            if (clr_addr_reg == {SLOT_BITS{1'b1}})
            begin
                clr_active_next = 1'b0;
            end
        end

        hist_next = accept ? hist_ext[HISTORY_BITS:1] : hist_reg;

        oq_wptr_next = oq_wptr_reg;
        oq_rptr_next = oq_rptr_reg;
        oq_cnt_next  = oq_cnt_reg;
        if (s1_valid_reg)
        begin
            oq_wptr_next = (oq_wptr_reg == OQ_LAST) ? 2'd0 : oq_wptr_reg + 2'd1;
        end
        if (pop)
        begin
            oq_rptr_next = (oq_rptr_reg == OQ_LAST) ? 2'd0 : oq_rptr_reg + 2'd1;
        end
        case ({s1_valid_reg, pop})
            2'b10:   oq_cnt_next = oq_cnt_reg + 2'd1;
            2'b01:   oq_cnt_next = oq_cnt_reg - 2'd1;
            default: oq_cnt_next = oq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            hist_reg       <= '1;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            tally_reg      <= '0;
            oq_wptr_reg    <= '0;
            oq_rptr_reg    <= '0;
            oq_cnt_reg     <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            hist_reg       <= hist_next;
            s1_valid_reg   <= accept;
            fwd_valid_reg  <= s1_valid_reg;
            tally_reg      <= tally_next;
            oq_wptr_reg    <= oq_wptr_next;
            oq_rptr_reg    <= oq_rptr_next;
            oq_cnt_reg     <= oq_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg  <= slot_in;
            s1_taken_reg <= actual_taken;
        end
        if (s1_valid_reg)
        begin
            fwd_slot_reg            <= s1_slot_reg;
            fwd_data_reg            <= ctr_new;
            oq_mem_reg[oq_wptr_reg] <= s1_result;
        end
    end

    // counter table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ctr_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= ctr_mem[slot_in];
        end
    end

    // output side
    assign head            = oq_mem_reg[oq_rptr_reg];
    assign result_valid    = (oq_cnt_reg != 2'd0);
    assign pop             = result_valid && result_ready;
    assign predicted_taken = head.predicted_taken;
    assign mispredicted    = head.mispredicted;
    assign miss_total      = head.miss_total;

    `CBP_ASSERT_IMPLY(a_no_accept_in_clear, clr_active_reg, !branch_ready)
    `CBP_ASSERT_IMPLY(a_no_update_in_clear, clr_active_reg, !s1_valid_reg)
    `CBP_ASSERT_IMPLY(a_oq_bound, 1'b1, oq_cnt_reg <= OQ_LAST + 2'd1)
    `CBP_ASSERT_NEXT(a_tally_step, s1_valid_reg && s1_miss && tally_reg != cbp_pkg::MISS_MAX, tally_reg == $past(tally_reg) + 32'd1)
    `CBP_ASSERT_NEXT(a_tally_hold, !s1_valid_reg || !s1_miss, $stable(tally_reg))

endmodule

>>> bench/tb_top.sv
// Self-checking bench for correlating_branch_predictor_core: directed and random branch words.
// Depends on cbp_pkg and the core RTL; a scoreboard class tracks the counter table state.
// Four handshake phases vary sender gaps and receiver stalls.
`timescale 1ns / 1ps

module tb_top;

    localparam int INDEX_BITS   = 10;
    localparam int HISTORY_BITS = 2;
    localparam int SLOT_BITS    = INDEX_BITS + HISTORY_BITS;
    localparam int TABLE_DEPTH  = 1 << SLOT_BITS;
    localparam int HOT_COUNT    = 6;

    typedef logic [HISTORY_BITS-1:0] history_t;
    typedef logic [SLOT_BITS-1:0]    slot_t;

    class branch_result_board;
        cbp_pkg::counter_t counters[TABLE_DEPTH];
        history_t history;
        logic [31:0] miss_tally;
        cbp_pkg::result_t pending[$];
        int failures;
        int words_checked;
        int misses_seen;

        function new();
            foreach (counters[i])
            begin
                counters[i] = cbp_pkg::CTR_RESET;
            end
            history = '1;
            miss_tally = '0;
            failures = 0;
            words_checked = 0;
            misses_seen = 0;
        endfunction

        function void note_branch(input logic [31:0] addr, input logic taken);
            slot_t slot;
            cbp_pkg::counter_t cur;
            history_t taken_bit;
            cbp_pkg::result_t res;
            slot = {addr[INDEX_BITS-1:0], history};
            cur = counters[slot];
            res.predicted_taken = (cur >= 2'd2);
            res.mispredicted = (res.predicted_taken != taken);
            if (res.mispredicted)
            begin
                case (cur)
                    2'd3:    counters[slot] = 2'd2;
                    2'd2:    counters[slot] = 2'd0;
                    2'd0:    counters[slot] = 2'd1;
                    default: counters[slot] = 2'd3;
                endcase
                if (miss_tally != cbp_pkg::MISS_MAX)
                begin
                    miss_tally = miss_tally + 32'd1;
                end
                misses_seen++;
            end
            else
            begin
                counters[slot] = res.predicted_taken ? 2'd3 : 2'd0;
            end
            taken_bit = history_t'(taken);
            history = (history >> 1) | (taken_bit << (HISTORY_BITS - 1));
            res.miss_total = miss_tally;
            pending.push_back(res);
        endfunction

        function void check_result(input logic pred, input logic miss, input logic [31:0] total);
            cbp_pkg::result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word pred=%0d miss=%0d total=%0d",
                         $time, pred, miss, total);
                failures++;
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (pred !== want.predicted_taken)
            begin
                $display("%0t: predicted_taken expected %0d actual %0d",
                         $time, want.predicted_taken, pred);
                failures++;
            end
            if (miss !== want.mispredicted)
            begin
                $display("%0t: mispredicted expected %0d actual %0d",
                         $time, want.mispredicted, miss);
                failures++;
            end
            if (total !== want.miss_total)
            begin
                $display("%0t: miss_total expected %0d actual %0d",
                         $time, want.miss_total, total);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        branch_valid = 1'b0;
    logic        branch_ready;
    logic [31:0] branch_address = '0;
    logic        actual_taken = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        predicted_taken;
    logic        mispredicted;
    logic [31:0] miss_total;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int words_sent = 0;
    logic [INDEX_BITS-1:0] hot_index[HOT_COUNT];
    int hot_period[HOT_COUNT];
    int hot_trip[HOT_COUNT];

    branch_result_board book = new();

    always #2 clk = ~clk;

    correlating_branch_predictor_core #(
        .INDEX_BITS   (INDEX_BITS),
        .HISTORY_BITS (HISTORY_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .branch_valid    (branch_valid),
        .branch_ready    (branch_ready),
        .branch_address  (branch_address),
        .actual_taken    (actual_taken),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .predicted_taken (predicted_taken),
        .mispredicted    (mispredicted),
        .miss_total      (miss_total)
    );

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            book.check_result(predicted_taken, mispredicted, miss_total);
        end
        result_ready <= (rst_n && $urandom_range(99) >= receiver_stall_pct);
    end

    task automatic drive_branch(input logic [31:0] addr, input logic taken);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            branch_valid <= 1'b0;
            @(posedge clk);
        end
        branch_valid <= 1'b1;
        branch_address <= addr;
        actual_taken <= taken;
        do
            @(posedge clk);
        while (!branch_ready);
        book.note_branch(addr, taken);
        words_sent++;
    endtask

    task automatic run_random(input int count);
        int pick;
        int h;
        logic [31:0] addr;
        logic taken;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            h = $urandom_range(HOT_COUNT - 1);
            addr = $urandom();
            if (pick < 80)
            begin
                // loop-like branch: taken until the trip count wraps
                addr[INDEX_BITS-1:0] = hot_index[h];
                hot_trip[h] = (hot_trip[h] + 1) % hot_period[h];
                taken = (hot_trip[h] != 0);
            end
            else if (pick < 90)
            begin
                addr[INDEX_BITS-1:0] = hot_index[h];
                taken = 1'($urandom_range(1));
            end
            else
            begin
                taken = 1'($urandom_range(1));
            end
            drive_branch(addr, taken);
        end
    endtask

    initial
    begin
        for (int i = 0; i < HOT_COUNT; i++)
        begin
            hot_index[i] = INDEX_BITS'($urandom());
            hot_period[i] = $urandom_range(5, 2);
            hot_trip[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // no idling: directed words first
        drive_branch(32'h0000_0000, 1'b0);
        drive_branch(32'hFFFF_FFFF, 1'b1);
        drive_branch(32'hFFFF_FC00, 1'b1);
        drive_branch(32'h0000_03FF, 1'b0);
        drive_branch(32'hAAAA_A800, 1'b0);
        drive_branch(32'h5555_57FF, 1'b1);
        // walk one counter through every state under history 00
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b1);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b1);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'h0000_0155, 1'b0);
        drive_branch(32'hFFFF_F955, 1'b1);
        drive_branch(32'h8000_0155, 1'b1);
        run_random(95);

        sender_idle_pct = 65;
        receiver_stall_pct = 0;
        run_random(115);

        sender_idle_pct = 0;
        receiver_stall_pct = 65;
        run_random(115);

        sender_idle_pct = 32;
        receiver_stall_pct = 32;
        run_random(115);

        branch_valid <= 1'b0;
        while (book.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d branch words across four gap/stall phases; checked %0d results.",
                 words_sent, book.words_checked);
        $display("Mispredictions seen: %0d; field mismatches: %0d.",
                 book.misses_seen, book.failures);
        if (book.failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timed out with %0d results outstanding.", book.pending.size());
        $display("status: fail");
        $finish;
    end

endmodule
